/* hw/rtl/fwts_pkg.sv */
// ----------------------------------------------------------------------------
// fwts_pkg
// Shared widths, operation and register codes, coefficient codes and the
// result record of the fixed-weight ternary sampler.
// ----------------------------------------------------------------------------
package fwts_pkg;

   localparam int POS_W      = 12;  // candidate position before the compare
   localparam int CMP_W      = 13;  // compare width, enough for DIM < 8192
   localparam int HW_W       = 10;
   localparam int WORD_W     = 16;
   localparam int SIGN_BIT   = 15;  // picks +1 or -1 for a placed coefficient
   localparam int RIDX_W     = 9;
   localparam int CNT_W      = 9;
   localparam int NUM_BLOCKS = 8;
   localparam int BLK_W      = 3;
   localparam int BLK_LSB    = 8;   // 256 coefficients per block
   localparam int COEF_W     = 2;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef logic [OP_W-1:0]      op_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef logic [COEF_W-1:0]    coef_type;

   localparam op_type OP_START = 2'd0;
   localparam op_type OP_WORD  = 2'd1;
   localparam op_type OP_READ  = 2'd2;

   localparam csr_idx_type CSR_DEGREE_MASK    = 2'd0;
   localparam csr_idx_type CSR_HAMMING_WEIGHT = 2'd1;

   localparam coef_type COEF_ZERO = 2'b00;
   localparam coef_type COEF_POS  = 2'b01;
   localparam coef_type COEF_NEG  = 2'b11;

   localparam logic [POS_W-1:0] DEGREE_MASK_RST    = 12'h3ff;
   localparam logic [HW_W-1:0]  HAMMING_WEIGHT_RST = 10'd140;

   typedef struct packed {
      logic                    accepted;
      logic                    done_res;
      logic signed [COEF_W-1:0] coefficient;
      logic [CNT_W-1:0]        block_count;
   } rsp_type;

   function automatic logic [BLK_W-1:0] blk_of(input logic [POS_W-1:0] idx);
      return idx[BLK_LSB+BLK_W-1:BLK_LSB];
   endfunction

endpackage

/* hw/rtl/fixed_weight_ternary_sampler.sv */
// ----------------------------------------------------------------------------
// fixed_weight_ternary_sampler
// Fixed-weight ternary polynomial sampler with a memory-held coefficient
// store and incremental per-block nonzero counts.
// Throughput: read and rejected-word beats one per cycle while the result
//   queue has room; an accepted random word holds off the next beat, as its
//   two writes share one write port.
// Reset clears control state and starts a clearing pass over all entries;
//   the same pass runs after every start beat, with req_ready low throughout.
// ----------------------------------------------------------------------------
module fixed_weight_ternary_sampler #(
   parameter int DIM = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [fwts_pkg::OP_W-1:0]           req_operation,
   input  logic [fwts_pkg::WORD_W-1:0]         req_random_word,
   input  logic [fwts_pkg::RIDX_W-1:0]         req_read_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_done_res,
   output logic signed [fwts_pkg::COEF_W-1:0]  rsp_coefficient,
   output logic [fwts_pkg::CNT_W-1:0]          rsp_block_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fwts_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fwts_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import fwts_pkg::*;

   localparam int IDX_W = $clog2(DIM);
   localparam int CUR_W = $clog2(DIM + 1);
   localparam logic [CUR_W-1:0] DIM_C = CUR_W'(DIM);

   // configuration
   logic [POS_W-1:0] degree_mask_ff, degree_mask_in;
   logic [HW_W-1:0]  hamming_weight_ff, hamming_weight_in;

   // sampler state
   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic             finished_ff, finished_in;
   logic [CNT_W-1:0] counts_ff [NUM_BLOCKS];
   logic [CNT_W-1:0] counts_in [NUM_BLOCKS];

   // accept stage
   logic             accept;
   logic             is_start;
   logic [POS_W-1:0] pos;
   logic             word_ok;
   logic [CUR_W-1:0] wsat;
   logic [IDX_W-1:0] rd_addr;

   // stage 1: memory data back
   logic             s1_valid_ff, s1_valid_in;
   op_type           s1_op_ff;
   logic             s1_acc_ff;
   coef_type         s1_place_ff;
   logic [IDX_W-1:0] s1_pos_ff;
   logic [IDX_W-1:0] s1_cur_ff;
   logic             s1_done_ff;
   logic             s1_rd_ok_ff;
   logic [BLK_W-1:0] s1_blk_ff;
   coef_type         moved;
   logic             moved_nz;
   logic             s1_wr;
   logic             is_read;
   logic [BLK_W-1:0] inc_blk;

   // stage 2: deferred write of the moved coefficient
   logic             s2_valid_ff, s2_valid_in;
   logic [IDX_W-1:0] s2_addr_ff;
   coef_type         s2_data_ff;

   // memory and queue
   logic             clr_busy;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   coef_type         wr_data;
   rsp_type          rsp_push;
   rsp_type          rsp_head;
   logic [FIFO_CNT_W-1:0] fifo_count;

   // ---------------------------------------------------------------- config
   assign csr_ready = 1'b1;

   always_comb begin
      degree_mask_in    = degree_mask_ff;
      hamming_weight_in = hamming_weight_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEGREE_MASK:    degree_mask_in    = csr_wdata;
            CSR_HAMMING_WEIGHT: hamming_weight_in = csr_wdata[HW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_mask_ff    <= DEGREE_MASK_RST;
         hamming_weight_ff <= HAMMING_WEIGHT_RST;
      end else begin
         degree_mask_ff    <= degree_mask_in;
         hamming_weight_ff <= hamming_weight_in;
      end
   end

   // ---------------------------------------------------------- accept stage
   // a placed word writes in stage 1, and in stage 2 for a nonzero moved value
   assign s1_wr     = s1_valid_ff & s1_acc_ff;
   assign req_ready = !clr_busy && !s1_wr &&
                      ((fifo_count + FIFO_CNT_W'(s1_valid_ff)) < FIFO_CNT_W'(FIFO_DEPTH));
   assign accept    = req_valid & req_ready;
   assign is_start  = accept && (req_operation == OP_START);

   always_comb begin
      pos     = req_random_word[POS_W-1:0] & degree_mask_ff;
      word_ok = (req_operation == OP_WORD) && !finished_ff && (cursor_ff < DIM_C) &&
                (CMP_W'(pos) <= CMP_W'(cursor_ff));
      wsat    = (CMP_W'(hamming_weight_ff) > CMP_W'(DIM)) ? DIM_C
                                                          : CUR_W'(hamming_weight_ff);
      rd_addr = (req_operation == OP_READ) ? IDX_W'(req_read_index) : IDX_W'(pos);
   end

   always_comb begin
      priority if (is_start) begin
         cursor_in   = DIM_C - wsat;
         finished_in = (wsat == '0);
      end else if (accept && word_ok) begin
         cursor_in   = cursor_ff + CUR_W'(1);
         finished_in = ((cursor_ff + CUR_W'(1)) == DIM_C);
      end else begin
         cursor_in   = cursor_ff;
         finished_in = finished_ff;
      end
   end

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         finished_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         finished_ff <= finished_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_operation;
         s1_acc_ff   <= word_ok;
         s1_place_ff <= req_random_word[SIGN_BIT] ? COEF_POS : COEF_NEG;
         s1_pos_ff   <= IDX_W'(pos);
         s1_cur_ff   <= IDX_W'(cursor_ff);
         s1_done_ff  <= finished_in;
         s1_rd_ok_ff <= (CMP_W'(req_read_index) < CMP_W'(DIM));
         s1_blk_ff   <= blk_of(POS_W'(req_read_index));
      end
   end

   // --------------------------------------------------------------- stage 1
   // the entry at the cursor is always zero, so only the moved value matters
   always_comb begin
      moved_nz    = (moved != COEF_ZERO);
      s2_valid_in = s1_wr && moved_nz;
      inc_blk     = moved_nz ? blk_of(POS_W'(s1_cur_ff)) : blk_of(POS_W'(s1_pos_ff));
      is_read     = s1_valid_ff && (s1_op_ff == OP_READ) && s1_rd_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         s2_addr_ff <= s1_cur_ff;
         s2_data_ff <= moved;
      end
   end

   always_comb begin
      wr_en   = s1_wr | s2_valid_ff;
      wr_addr = s1_wr ? s1_pos_ff : s2_addr_ff;
      wr_data = s1_wr ? s1_place_ff : s2_data_ff;
   end

   // net effect of a placement: one more nonzero in exactly one block
   always_comb begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         priority if (is_start) begin
            counts_in[i] = '0;
         end else if (s1_wr && (inc_blk == BLK_W'(i))) begin
            counts_in[i] = counts_ff[i] + CNT_W'(1);
         end else begin
            counts_in[i] = counts_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         if (reset) begin
            counts_ff[i] <= '0;
         end else begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   always_comb begin
      rsp_push.accepted    = s1_acc_ff;
      rsp_push.done_res    = s1_done_ff;
      rsp_push.coefficient = is_read ? $signed(moved) : $signed(COEF_ZERO);
      rsp_push.block_count = is_read ? counts_ff[s1_blk_ff] : '0;
   end

   // ------------------------------------------------------------ submodules
   fwts_coeff_store #(
      .DEPTH (DIM)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .clr_start (is_start),
      .clr_busy  (clr_busy),
      .rd_en     (accept),
      .rd_addr   (rd_addr),
      .rd_data   (moved),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   fwts_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (rsp_push),
      .pop       (rsp_valid & rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_head),
      .count     (fifo_count)
   );

   assign rsp_accepted    = rsp_head.accepted;
   assign rsp_done_res    = rsp_head.done_res;
   assign rsp_coefficient = rsp_head.coefficient;
   assign rsp_block_count = rsp_head.block_count;

   // ------------------------------------------------------------ assertions
   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !wr_en)
      else $error("coefficient write while clearing pass runs");

   a_single_writer: assert property (@(posedge clock) disable iff (reset)
      !(s1_wr && s2_valid_ff))
      else $error("placement and moved-value writes collide");

   a_cursor_step: assert property (@(posedge clock) disable iff (reset)
      (accept && word_ok) |=> (cursor_ff == $past(cursor_ff) + CUR_W'(1)))
      else $error("cursor did not advance on a placed word");

   a_finished_at_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff == (cursor_ff == DIM_C))
      else $error("finished flag out of step with cursor");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result pushed into a full queue");

endmodule

/* hw/rtl/fwts_coeff_store.sv */
// ----------------------------------------------------------------------------
// fwts_coeff_store
// Coefficient memory: one write port, one registered read port with
// write-first bypass, and a clearing pass after reset and on request.
// ----------------------------------------------------------------------------
module fwts_coeff_store #(
   parameter int DEPTH = 512
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clr_start,
   output logic                         clr_busy,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [fwts_pkg::COEF_W-1:0]  rd_data,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [fwts_pkg::COEF_W-1:0]  wr_data
);
   import fwts_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   logic [COEF_W-1:0] mem [DEPTH];
   logic [COEF_W-1:0] rd_data_ff;
   logic              clr_active_ff, clr_active_in;
   logic [AW-1:0]     clr_idx_ff, clr_idx_in;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [COEF_W-1:0] wdata;

   // the clearing pass owns the write port while it runs
   always_comb begin
      we    = clr_active_ff | wr_en;
      waddr = clr_active_ff ? clr_idx_ff : wr_addr;
      wdata = clr_active_ff ? COEF_ZERO : wr_data;
   end

   always_comb begin
      priority if (clr_start) begin
         clr_active_in = 1'b1;
         clr_idx_in    = '0;
      end else if (clr_active_ff) begin
         clr_active_in = (clr_idx_ff != LAST);
         clr_idx_in    = clr_idx_ff + AW'(1);
      end else begin
         clr_active_in = clr_active_ff;
         clr_idx_in    = clr_idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= (we && (waddr == rd_addr)) ? wdata : mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_active_ff;

endmodule

/* hw/rtl/fwts_rsp_fifo.sv */
// ----------------------------------------------------------------------------
// fwts_rsp_fifo
// Small result queue between the pipeline and the rsp channel.
// ----------------------------------------------------------------------------
module fwts_rsp_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  fwts_pkg::rsp_type                 push_data,
   input  logic                              pop,
   output logic                              out_valid,
   output fwts_pkg::rsp_type                 out_data,
   output logic [fwts_pkg::FIFO_CNT_W-1:0]   count
);
   import fwts_pkg::*;

   rsp_type                q_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  head_ff, head_in;
   logic [FIFO_PTR_W-1:0]  tail_ff, tail_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = pop  ? head_ff + FIFO_PTR_W'(1) : head_ff;
      tail_in  = push ? tail_ff + FIFO_PTR_W'(1) : tail_ff;
      count_in = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = q_ff[head_ff];
   assign count     = count_ff;

endmodule
